/* hdl/i2c_rm_pkg.sv */
// Package for the register-addressed I2C master: bus phase and stage codes,
// the sequencer state record, the result record and the state update helpers.
// Depends on nothing; used by i2c_register_master_core and the testbench.
package i2c_rm_pkg;

  // Action codes carried with every tick.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_DATA  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [1:0] CFG_POLL_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TICKS      = 2'd2;

  // Configuration reset values.
  localparam logic [6:0]  DEV_ADDR_RST   = 7'd127;
  localparam logic [7:0]  POLL_LIMIT_RST = 8'd100;
  localparam logic [15:0] TICKS_RST      = 16'd1;

  typedef enum logic [21:0] {
    PH_IDLE      = 22'h000001,
    PH_START_PRE = 22'h000002,
    PH_START_A1  = 22'h000004,
    PH_START_A2  = 22'h000008,
    PH_START_B   = 22'h000010,
    PH_BIT_L     = 22'h000020,
    PH_BIT_H1    = 22'h000040,
    PH_BIT_H2    = 22'h000080,
    PH_TAIL1     = 22'h000100,
    PH_TAIL2     = 22'h000200,
    PH_ACK_L     = 22'h000400,
    PH_ACK_H     = 22'h000800,
    PH_ACK_POLL  = 22'h001000,
    PH_WAIT_DATA = 22'h002000,
    PH_RD_L      = 22'h004000,
    PH_RD_H      = 22'h008000,
    PH_MACK_L    = 22'h010000,
    PH_MACK_H    = 22'h020000,
    PH_STOP_0    = 22'h040000,
    PH_STOP_A    = 22'h080000,
    PH_STOP_B    = 22'h100000,
    PH_STOP_C    = 22'h200000
  } phase_e;

  // Which byte of the transfer is on the wire.
  typedef enum logic [1:0] {
    ST_ADDR_W = 2'd0,
    ST_REG    = 2'd1,
    ST_ADDR_R = 2'd2,
    ST_DATA   = 2'd3
  } stage_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  bit_index;
    logic [7:0]  shift_byte;
    logic [7:0]  bytes_left;
    logic [15:0] delay_count;
    logic [7:0]  poll_count;
    logic [7:0]  held_register;
    logic        is_read;
    logic        scl;
    logic        sda;
    stage_e      stage;
    logic        drive;
    logic        failed;
  } seq_t;

  // One result item, in the order it is packed onto the output bus; read_last leaves on tlast.
  typedef struct packed {
    logic       ack_error;
    logic       done_res;
    logic       busy_res;
    logic       need_write_data;
    logic       read_last;
    logic       read_valid;
    logic [7:0] read_data;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

  // Enter a new bus phase with the given pin levels and restart the delay.
  // A released SDA line always reads back as high.
  function automatic seq_t go(seq_t s, phase_e ph, logic scl, logic sda, logic drv);
    seq_t r;
    r             = s;
    r.phase       = ph;
    r.scl         = scl;
    r.drive       = drv;
    r.sda         = drv ? sda : 1'b1;
    r.delay_count = '0;
    return r;
  endfunction

  function automatic seq_t send_bit_low(seq_t s);
    return go(s, PH_BIT_L, 1'b0, s.shift_byte[7], 1'b1);
  endfunction

  // STOP begins with SCL low and SDA left as it is.
  function automatic seq_t begin_stop(seq_t s);
    return go(s, PH_STOP_0, 1'b0, s.sda, s.drive);
  endfunction

  // The target acknowledged: move on to the next byte of the transfer, or begin STOP when none is left.
  function automatic seq_t after_ack(seq_t s);
    seq_t r;
    r = s;
    case (s.stage)
      ST_ADDR_W: begin
        r.stage      = ST_REG;
        r.shift_byte = s.held_register;
        r.bit_index  = '0;
        r            = send_bit_low(r);
      end
      ST_REG: begin
        if (s.is_read) begin
          r.stage = ST_ADDR_R;
          r       = go(r, PH_START_PRE, 1'b0, 1'b1, 1'b1);
        end else if (s.bytes_left == 8'd0) begin
          r = begin_stop(r);
        end else begin
          r.stage = ST_DATA;
          r       = go(r, PH_WAIT_DATA, 1'b0, 1'b1, 1'b0);
        end
      end
      ST_ADDR_R: begin
        if (s.bytes_left == 8'd0) begin
          r = begin_stop(r);
        end else begin
          r.stage      = ST_DATA;
          r.shift_byte = '0;
          r.bit_index  = '0;
          r            = go(r, PH_RD_L, 1'b0, 1'b1, 1'b0);
        end
      end
      default: begin
        r.bytes_left = s.bytes_left - 8'd1;
        if (r.bytes_left == 8'd0) begin
          r = begin_stop(r);
        end else begin
          r = go(r, PH_WAIT_DATA, 1'b0, 1'b1, 1'b0);
        end
      end
    endcase
    return r;
  endfunction

endpackage

/* hdl/i2c_register_master_core.sv */
// Top level of the register-addressed I2C master: tick-driven bus sequencer
// with a registered result stage. Depends on i2c_rm_pkg.
//
// Usage. Every transfer on the slave stream is one bus tick. It carries the
// sampled SDA level and an action in tuser: a plain tick, the start of a
// register write, the start of a register read, or the next write byte.
// A register transfer sends START, the device address with the write bit and
// the register byte; a write then sends the data bytes one by one as they are
// supplied, while a read sends a repeated START and the address with the read
// bit, and receives the bytes MSB first, acknowledging all but the last.
// Every transfer ends with STOP, also when an acknowledge fails to arrive
// within the poll limit, in which case ack_error is raised alongside done.
// For every accepted tick exactly one result transfer leaves on the master
// stream, carrying the pin levels and status after that tick.
// The sequencer state and the result register are both updated at the edge
// that accepts the tick. One tick is taken in every cycle while the receiver
// keeps up, set by the single sequencer update between the state and result registers.
// When the receiver stalls, the result waits in the output register and the
// slave side is held off until it has been taken; no tick is lost.
// Reset releases the bus (SCL and SDA high), empties the output register and
// restores the configuration to its reset values. The configuration port must be
// written only while the block is idle; the block itself does not enforce this.
module i2c_register_master_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Tick stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, from bit 0: reg_address[7:0], byte_count[15:8], write_data[23:16],
  // sda_in[24], zero padding[31:25].
  input  logic [31:0] s_axis_tdata,
  // tuser: action[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result stream out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, from bit 0: scl_level[0], sda_level[1], sda_drive[2],
  // read_data[10:3], read_valid[11], need_write_data[12], busy_res[13],
  // done_res[14], ack_error[15].
  output logic [15:0] m_axis_tdata,
  // tlast: read_last, the received byte is the final one of the read.
  output logic        m_axis_tlast
);

  // Configuration registers.
  logic [6:0]  dev_addr_q;
  logic [7:0]  poll_limit_q;
  logic [15:0] ticks_q;

  // Sequencer state and its next value.
  i2c_rm_pkg::seq_t seq_q, seq_d;

  // Output register.
  logic             out_valid_q;
  i2c_rm_pkg::res_t res_q, res_d;

  logic accept;

  // A new tick is taken whenever the output register is free or being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= i2c_rm_pkg::DEV_ADDR_RST;
      poll_limit_q <= i2c_rm_pkg::POLL_LIMIT_RST;
      ticks_q      <= i2c_rm_pkg::TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        i2c_rm_pkg::CFG_DEV_ADDR:   dev_addr_q   <= cfg_data_i[6:0];
        i2c_rm_pkg::CFG_POLL_LIMIT: poll_limit_q <= cfg_data_i[7:0];
        i2c_rm_pkg::CFG_TICKS:      ticks_q      <= cfg_data_i;
        default: begin
          // Writes to indexes beyond the register list are dropped.
        end
      endcase
    end
  end

  // Sequencer: one bus tick per accepted transfer.
  always_comb begin
    logic [1:0]  action;
    logic [7:0]  in_reg;
    logic [7:0]  in_count;
    logic [7:0]  in_wdata;
    logic        sda_in;
    logic [15:0] unit;
    logic [16:0] dly_inc;
    logic        expired;
    logic        rd_valid;
    logic        rd_last;
    logic [7:0]  rd_data;
    logic        done;
    logic        err;

    action   = s_axis_tuser;
    in_reg   = s_axis_tdata[7:0];
    in_count = s_axis_tdata[15:8];
    in_wdata = s_axis_tdata[23:16];
    sda_in   = s_axis_tdata[24];
    rd_valid = 1'b0;
    rd_last  = 1'b0;
    rd_data  = '0;
    done     = 1'b0;
    err      = 1'b0;
    seq_d    = seq_q;

    // A zero delay unit behaves as one tick.
    unit    = (ticks_q == 16'd0) ? 16'd1 : ticks_q;
    dly_inc = {1'b0, seq_q.delay_count} + 17'd1;
    expired = 1'b0;
    if (seq_q.phase != i2c_rm_pkg::PH_IDLE && seq_q.phase != i2c_rm_pkg::PH_WAIT_DATA &&
        seq_q.phase != i2c_rm_pkg::PH_ACK_POLL) begin
      if (dly_inc >= {1'b0, unit}) begin
        expired = 1'b1;
      end else begin
        seq_d.delay_count = dly_inc[15:0];
      end
    end

    case (seq_q.phase)
      i2c_rm_pkg::PH_IDLE: begin
        if (action == i2c_rm_pkg::ACT_WRITE || action == i2c_rm_pkg::ACT_READ) begin
          seq_d.held_register = in_reg;
          seq_d.bytes_left    = in_count;
          seq_d.is_read       = (action == i2c_rm_pkg::ACT_READ);
          seq_d.stage         = i2c_rm_pkg::ST_ADDR_W;
          seq_d.failed        = 1'b0;
          seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_START_A1, 1'b1, 1'b1, 1'b1);
        end
      end
      i2c_rm_pkg::PH_START_PRE: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_START_A1, 1'b1, 1'b1, 1'b1);
      end
      i2c_rm_pkg::PH_START_A1: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_START_A2, 1'b1, 1'b1, 1'b1);
      end
      i2c_rm_pkg::PH_START_A2: begin
        // SDA falls while SCL is high: the START condition.
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_START_B, 1'b1, 1'b0, 1'b1);
      end
      i2c_rm_pkg::PH_START_B: begin
        if (expired) begin
          seq_d.shift_byte = {dev_addr_q, (seq_q.stage == i2c_rm_pkg::ST_ADDR_R)};
          seq_d.bit_index  = '0;
          seq_d = i2c_rm_pkg::send_bit_low(seq_d);
        end
      end
      i2c_rm_pkg::PH_BIT_L: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_BIT_H1, 1'b1, seq_q.sda, 1'b1);
      end
      i2c_rm_pkg::PH_BIT_H1: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_BIT_H2, 1'b1, seq_q.sda, 1'b1);
      end
      i2c_rm_pkg::PH_BIT_H2: begin
        if (expired) begin
          seq_d.shift_byte = {seq_q.shift_byte[6:0], 1'b0};
          seq_d.bit_index  = seq_q.bit_index + 4'd1;
          if (seq_d.bit_index >= 4'd8) begin
            seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_TAIL1, 1'b0, seq_q.sda, 1'b1);
          end else begin
            seq_d = i2c_rm_pkg::send_bit_low(seq_d);
          end
        end
      end
      i2c_rm_pkg::PH_TAIL1: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_TAIL2, 1'b0, seq_q.sda, 1'b1);
      end
      i2c_rm_pkg::PH_TAIL2: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_ACK_L, 1'b0, 1'b1, 1'b0);
      end
      i2c_rm_pkg::PH_ACK_L: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_ACK_H, 1'b1, 1'b1, 1'b0);
      end
      i2c_rm_pkg::PH_ACK_H: begin
        if (expired) begin
          seq_d.poll_count = '0;
          seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_ACK_POLL, 1'b1, 1'b1, 1'b0);
        end
      end
      i2c_rm_pkg::PH_ACK_POLL: begin
        // SDA is sampled once per tick; a low level is the acknowledge.
        if (!sda_in) begin
          seq_d = i2c_rm_pkg::after_ack(seq_d);
        end else if (seq_q.poll_count >= poll_limit_q) begin
          seq_d.failed = 1'b1;
          seq_d = i2c_rm_pkg::begin_stop(seq_d);
        end else begin
          seq_d.poll_count = seq_q.poll_count + 8'd1;
        end
      end
      i2c_rm_pkg::PH_WAIT_DATA: begin
        if (action == i2c_rm_pkg::ACT_DATA) begin
          seq_d.shift_byte = in_wdata;
          seq_d.bit_index  = '0;
          seq_d = i2c_rm_pkg::send_bit_low(seq_d);
        end
      end
      i2c_rm_pkg::PH_RD_L: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_RD_H, 1'b1, 1'b1, 1'b0);
      end
      i2c_rm_pkg::PH_RD_H: begin
        if (expired) begin
          seq_d.shift_byte = {seq_q.shift_byte[6:0], sda_in};
          seq_d.bit_index  = seq_q.bit_index + 4'd1;
          if (seq_d.bit_index >= 4'd8) begin
            // Byte complete: present it and answer with ACK, or NACK on the last.
            rd_valid = 1'b1;
            rd_data  = seq_d.shift_byte;
            rd_last  = (seq_q.bytes_left == 8'd1);
            seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_MACK_L, 1'b0, rd_last, 1'b1);
          end else begin
            seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_RD_L, 1'b0, 1'b1, 1'b0);
          end
        end
      end
      i2c_rm_pkg::PH_MACK_L: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_MACK_H, 1'b1, seq_q.sda, 1'b1);
      end
      i2c_rm_pkg::PH_MACK_H: begin
        if (expired) begin
          seq_d.bytes_left = seq_q.bytes_left - 8'd1;
          if (seq_d.bytes_left == 8'd0) begin
            seq_d = i2c_rm_pkg::begin_stop(seq_d);
          end else begin
            seq_d.shift_byte = '0;
            seq_d.bit_index  = '0;
            seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_RD_L, 1'b0, 1'b1, 1'b0);
          end
        end
      end
      i2c_rm_pkg::PH_STOP_0: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_STOP_A, 1'b0, 1'b0, 1'b1);
      end
      i2c_rm_pkg::PH_STOP_A: begin
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_STOP_B, 1'b1, 1'b0, 1'b1);
      end
      i2c_rm_pkg::PH_STOP_B: begin
        // SDA rises while SCL is high: the STOP condition.
        if (expired) seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_STOP_C, 1'b1, 1'b1, 1'b1);
      end
      i2c_rm_pkg::PH_STOP_C: begin
        if (expired) begin
          done         = 1'b1;
          err          = seq_q.failed;
          seq_d.failed = 1'b0;
          seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_IDLE, 1'b1, 1'b1, 1'b1);
        end
      end
      default: begin
        seq_d = i2c_rm_pkg::go(seq_d, i2c_rm_pkg::PH_IDLE, 1'b1, 1'b1, 1'b1);
      end
    endcase

    res_d.scl_level       = seq_d.scl;
    res_d.sda_level       = seq_d.drive ? seq_d.sda : 1'b1;
    res_d.sda_drive       = seq_d.drive;
    res_d.read_data       = rd_data;
    res_d.read_valid      = rd_valid;
    res_d.read_last       = rd_last;
    res_d.need_write_data = (seq_d.phase == i2c_rm_pkg::PH_WAIT_DATA);
    res_d.busy_res        = (seq_d.phase != i2c_rm_pkg::PH_IDLE);
    res_d.done_res        = done;
    res_d.ack_error       = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.phase         <= i2c_rm_pkg::PH_IDLE;
      seq_q.bit_index     <= '0;
      seq_q.shift_byte    <= '0;
      seq_q.bytes_left    <= '0;
      seq_q.delay_count   <= '0;
      seq_q.poll_count    <= '0;
      seq_q.held_register <= '0;
      seq_q.is_read       <= 1'b0;
      seq_q.scl           <= 1'b1;
      seq_q.sda           <= 1'b1;
      seq_q.stage         <= i2c_rm_pkg::ST_ADDR_W;
      seq_q.drive         <= 1'b1;
      seq_q.failed        <= 1'b0;
    end else if (accept) begin
      seq_q <= seq_d;
    end
  end

  // Output register: the valid flag is reset, the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.ack_error, res_q.done_res, res_q.busy_res,
                          res_q.need_write_data, res_q.read_valid, res_q.read_data,
                          res_q.sda_drive, res_q.sda_level, res_q.scl_level};
  assign m_axis_tlast  = res_q.read_last;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for i2c_register_master_core: drives bus ticks with scripted
// target behaviour and compares every result against a tick-by-tick sequencer predictor.
// Depends on i2c_rm_pkg and the core RTL only.
module testbench;

  // Watchdog: cycles in a row with no transfer on either stream before the run is abandoned.
  // The longest legitimate quiet stretch is the deliberate output hold-off below.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 400;
  // A planned acknowledge delay beyond any poll count, so the target never answers.
  localparam int NEVER_ACK = 300;

  // One input tick as the sender sees it.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] regad;
    logic [7:0] count;
    logic [7:0] wdata;
    logic       sda;
  } bus_tick_t;

  // One result: pin levels and status after a tick.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic [7:0] rdata;
    logic       rvalid;
    logic       rlast;
    logic       need;
    logic       busy;
    logic       done;
    logic       err;
  } bus_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = i2c_rm_pkg::ACT_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  i2c_register_master_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Stimulus knobs. The idle percentages shape both handshakes; the others shape how the
  // scripted target and the noise generator behave within one register access. The ack
  // budget is the number of acknowledges the target gives before it falls silent; a
  // negative budget means it never runs out.
  int tx_idle_pct = 33;
  int rx_idle_pct = 49;
  int abort_pct = 0;
  int noise_pct = 0;
  int ack_budget = -1;
  logic rx_hold = 1'b0;

  // Sequencer predictor: its own copy of the bus state and of the three registers.
  i2c_rm_pkg::phase_e p_phase;
  i2c_rm_pkg::stage_e p_stage;
  logic [3:0]  p_bits;
  logic [7:0]  p_shift;
  logic [7:0]  p_left;
  logic [7:0]  p_polls;
  logic [7:0]  p_reg;
  logic [15:0] p_delay;
  logic        p_read;
  logic        p_scl;
  logic        p_sda;
  logic        p_drive;
  logic        p_failed;
  logic [6:0]  cfg_dev;
  logic [7:0]  cfg_limit;
  logic [15:0] cfg_tpd;

  // Results still owed by the block, oldest first.
  bus_res_t pending_results[$];
  bus_res_t got_res;
  bus_res_t want_res;

  int mismatches = 0;
  int results_checked = 0;
  int ticks_sent = 0;
  int accesses = 0;
  int settings_used = 0;
  int bytes_read = 0;
  int stops_seen = 0;
  int aborts_seen = 0;
  int quiet_cycles = 0;

  function automatic void reset_predictor();
    cfg_dev   = i2c_rm_pkg::DEV_ADDR_RST;
    cfg_limit = i2c_rm_pkg::POLL_LIMIT_RST;
    cfg_tpd   = i2c_rm_pkg::TICKS_RST;
    p_phase   = i2c_rm_pkg::PH_IDLE;
    p_stage   = i2c_rm_pkg::ST_ADDR_W;
    p_bits    = '0;
    p_shift   = '0;
    p_left    = '0;
    p_polls   = '0;
    p_reg     = '0;
    p_delay   = '0;
    p_read    = 1'b0;
    p_scl     = 1'b1;
    p_sda     = 1'b1;
    p_drive   = 1'b1;
    p_failed  = 1'b0;
  endfunction

  // Enter a bus phase with new pin levels; a released SDA line reads as high.
  function automatic void move_to(i2c_rm_pkg::phase_e ph, logic scl, logic sda, logic drv);
    p_phase = ph;
    p_scl   = scl;
    p_drive = drv;
    p_sda   = drv ? sda : 1'b1;
    p_delay = '0;
  endfunction

  function automatic void shift_next_bit();
    move_to(i2c_rm_pkg::PH_BIT_L, 1'b0, p_shift[7], 1'b1);
  endfunction

  function automatic void open_stop();
    move_to(i2c_rm_pkg::PH_STOP_0, 1'b0, p_sda, p_drive);
  endfunction

  // The target pulled SDA low in the acknowledge slot: pick the next byte or finish.
  function automatic void target_acked();
    case (p_stage)
      i2c_rm_pkg::ST_ADDR_W: begin
        p_stage = i2c_rm_pkg::ST_REG;
        p_shift = p_reg;
        p_bits  = '0;
        shift_next_bit();
      end
      i2c_rm_pkg::ST_REG: begin
        if (p_read) begin
          p_stage = i2c_rm_pkg::ST_ADDR_R;
          move_to(i2c_rm_pkg::PH_START_PRE, 1'b0, 1'b1, 1'b1);
        end else if (p_left == 8'd0) begin
          open_stop();
        end else begin
          p_stage = i2c_rm_pkg::ST_DATA;
          move_to(i2c_rm_pkg::PH_WAIT_DATA, 1'b0, 1'b1, 1'b0);
        end
      end
      i2c_rm_pkg::ST_ADDR_R: begin
        if (p_left == 8'd0) begin
          open_stop();
        end else begin
          p_stage = i2c_rm_pkg::ST_DATA;
          p_shift = '0;
          p_bits  = '0;
          move_to(i2c_rm_pkg::PH_RD_L, 1'b0, 1'b1, 1'b0);
        end
      end
      default: begin
        p_left = p_left - 8'd1;
        if (p_left == 8'd0) open_stop();
        else move_to(i2c_rm_pkg::PH_WAIT_DATA, 1'b0, 1'b1, 1'b0);
      end
    endcase
  endfunction

  // Advance the predicted sequencer by one tick and return the result it should produce.
  function automatic bus_res_t predict_tick(bus_tick_t t);
    bus_res_t    r;
    logic [16:0] unit;
    logic        expired;
    r       = '0;
    unit    = (cfg_tpd == 16'd0) ? 17'd1 : {1'b0, cfg_tpd};
    expired = 1'b0;
    if (p_phase != i2c_rm_pkg::PH_IDLE && p_phase != i2c_rm_pkg::PH_WAIT_DATA &&
        p_phase != i2c_rm_pkg::PH_ACK_POLL) begin
      if ({1'b0, p_delay} + 17'd1 >= unit) expired = 1'b1;
      else p_delay = p_delay + 16'd1;
    end
    case (p_phase)
      i2c_rm_pkg::PH_IDLE: begin
        if (t.action == i2c_rm_pkg::ACT_WRITE || t.action == i2c_rm_pkg::ACT_READ) begin
          p_reg    = t.regad;
          p_left   = t.count;
          p_read   = (t.action == i2c_rm_pkg::ACT_READ);
          p_stage  = i2c_rm_pkg::ST_ADDR_W;
          p_failed = 1'b0;
          move_to(i2c_rm_pkg::PH_START_A1, 1'b1, 1'b1, 1'b1);
        end
      end
      i2c_rm_pkg::PH_START_PRE: begin
        if (expired) move_to(i2c_rm_pkg::PH_START_A1, 1'b1, 1'b1, 1'b1);
      end
      i2c_rm_pkg::PH_START_A1: begin
        if (expired) move_to(i2c_rm_pkg::PH_START_A2, 1'b1, 1'b1, 1'b1);
      end
      i2c_rm_pkg::PH_START_A2: begin
        if (expired) move_to(i2c_rm_pkg::PH_START_B, 1'b1, 1'b0, 1'b1);
      end
      i2c_rm_pkg::PH_START_B: begin
        if (expired) begin
          p_shift = {cfg_dev, p_stage == i2c_rm_pkg::ST_ADDR_R};
          p_bits  = '0;
          shift_next_bit();
        end
      end
      i2c_rm_pkg::PH_BIT_L: begin
        if (expired) move_to(i2c_rm_pkg::PH_BIT_H1, 1'b1, p_sda, 1'b1);
      end
      i2c_rm_pkg::PH_BIT_H1: begin
        if (expired) move_to(i2c_rm_pkg::PH_BIT_H2, 1'b1, p_sda, 1'b1);
      end
      i2c_rm_pkg::PH_BIT_H2: begin
        if (expired) begin
          p_shift = p_shift << 1;
          p_bits  = p_bits + 4'd1;
          if (p_bits >= 4'd8) move_to(i2c_rm_pkg::PH_TAIL1, 1'b0, p_sda, 1'b1);
          else shift_next_bit();
        end
      end
      i2c_rm_pkg::PH_TAIL1: begin
        if (expired) move_to(i2c_rm_pkg::PH_TAIL2, 1'b0, p_sda, 1'b1);
      end
      i2c_rm_pkg::PH_TAIL2: begin
        if (expired) move_to(i2c_rm_pkg::PH_ACK_L, 1'b0, 1'b1, 1'b0);
      end
      i2c_rm_pkg::PH_ACK_L: begin
        if (expired) move_to(i2c_rm_pkg::PH_ACK_H, 1'b1, 1'b1, 1'b0);
      end
      i2c_rm_pkg::PH_ACK_H: begin
        if (expired) begin
          p_polls = '0;
          move_to(i2c_rm_pkg::PH_ACK_POLL, 1'b1, 1'b1, 1'b0);
        end
      end
      i2c_rm_pkg::PH_ACK_POLL: begin
        if (!t.sda) begin
          target_acked();
        end else if (p_polls >= cfg_limit) begin
          p_failed = 1'b1;
          open_stop();
        end else begin
          p_polls = p_polls + 8'd1;
        end
      end
      i2c_rm_pkg::PH_WAIT_DATA: begin
        if (t.action == i2c_rm_pkg::ACT_DATA) begin
          p_shift = t.wdata;
          p_bits  = '0;
          shift_next_bit();
        end
      end
      i2c_rm_pkg::PH_RD_L: begin
        if (expired) move_to(i2c_rm_pkg::PH_RD_H, 1'b1, 1'b1, 1'b0);
      end
      i2c_rm_pkg::PH_RD_H: begin
        if (expired) begin
          p_shift = {p_shift[6:0], t.sda};
          p_bits  = p_bits + 4'd1;
          if (p_bits >= 4'd8) begin
            r.rvalid = 1'b1;
            r.rdata  = p_shift;
            r.rlast  = (p_left == 8'd1);
            move_to(i2c_rm_pkg::PH_MACK_L, 1'b0, r.rlast, 1'b1);
          end else begin
            move_to(i2c_rm_pkg::PH_RD_L, 1'b0, 1'b1, 1'b0);
          end
        end
      end
      i2c_rm_pkg::PH_MACK_L: begin
        if (expired) move_to(i2c_rm_pkg::PH_MACK_H, 1'b1, p_sda, 1'b1);
      end
      i2c_rm_pkg::PH_MACK_H: begin
        if (expired) begin
          p_left = p_left - 8'd1;
          if (p_left == 8'd0) begin
            open_stop();
          end else begin
            p_shift = '0;
            p_bits  = '0;
            move_to(i2c_rm_pkg::PH_RD_L, 1'b0, 1'b1, 1'b0);
          end
        end
      end
      i2c_rm_pkg::PH_STOP_0: begin
        if (expired) move_to(i2c_rm_pkg::PH_STOP_A, 1'b0, 1'b0, 1'b1);
      end
      i2c_rm_pkg::PH_STOP_A: begin
        if (expired) move_to(i2c_rm_pkg::PH_STOP_B, 1'b1, 1'b0, 1'b1);
      end
      i2c_rm_pkg::PH_STOP_B: begin
        if (expired) move_to(i2c_rm_pkg::PH_STOP_C, 1'b1, 1'b1, 1'b1);
      end
      i2c_rm_pkg::PH_STOP_C: begin
        if (expired) begin
          r.done   = 1'b1;
          r.err    = p_failed;
          p_failed = 1'b0;
          move_to(i2c_rm_pkg::PH_IDLE, 1'b1, 1'b1, 1'b1);
        end
      end
      default: move_to(i2c_rm_pkg::PH_IDLE, 1'b1, 1'b1, 1'b1);
    endcase
    r.scl   = p_scl;
    r.sda   = p_drive ? p_sda : 1'b1;
    r.drive = p_drive;
    r.need  = (p_phase == i2c_rm_pkg::PH_WAIT_DATA);
    r.busy  = (p_phase != i2c_rm_pkg::PH_IDLE);
    return r;
  endfunction

  // Output stream: the receiver stalls at random, or solidly while a hold-off is running.
  always @(negedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic bus_res_t observed_result();
    bus_res_t r;
    r.scl    = m_axis_tdata[0];
    r.sda    = m_axis_tdata[1];
    r.drive  = m_axis_tdata[2];
    r.rdata  = m_axis_tdata[10:3];
    r.rvalid = m_axis_tdata[11];
    r.need   = m_axis_tdata[12];
    r.busy   = m_axis_tdata[13];
    r.done   = m_axis_tdata[14];
    r.err    = m_axis_tdata[15];
    r.rlast  = m_axis_tlast;
    return r;
  endfunction

  task automatic field_check(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h, got %0h", results_checked, name, want, got);
    end
  endtask

  task automatic compare_result(input bus_res_t want, input bus_res_t got);
    results_checked++;
    if (want.rvalid) bytes_read++;
    if (want.done) stops_seen++;
    if (want.err) aborts_seen++;
    field_check("scl_level", want.scl, got.scl);
    field_check("sda_level", want.sda, got.sda);
    field_check("sda_drive", want.drive, got.drive);
    field_check("read_data", want.rdata, got.rdata);
    field_check("read_valid", want.rvalid, got.rvalid);
    field_check("read_last", want.rlast, got.rlast);
    field_check("need_write_data", want.need, got.need);
    field_check("busy", want.busy, got.busy);
    field_check("done", want.done, got.done);
    field_check("ack_error", want.err, got.err);
  endtask

  // Every result transfer is checked against the oldest outstanding prediction. Sampling in
  // the active region of the rising edge sees the values from before that edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = observed_result();
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no prediction outstanding: %h", got_res);
      end else begin
        want_res = pending_results.pop_front();
        compare_result(want_res, got_res);
      end
    end
  end

  // Watchdog on forward progress of either stream.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one tick after a random gap and hold it until it is taken; the prediction is
  // made at the accepting edge so the next tick can be chosen from the new bus state.
  task automatic send_tick(input bus_tick_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, t.sda, t.wdata, t.count, t.regad};
    s_axis_tuser  <= t.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_tick(t));
    ticks_sent++;
  endtask

  function automatic bus_tick_t rand_tick(input logic [1:0] act);
    bus_tick_t t;
    t.action = act;
    t.regad  = 8'($urandom);
    t.count  = 8'($urandom);
    t.wdata  = 8'($urandom);
    t.sda    = 1'($urandom);
    return t;
  endfunction

  function automatic logic [1:0] noise_action();
    case ($urandom_range(2))
      0:       return i2c_rm_pkg::ACT_WRITE;
      1:       return i2c_rm_pkg::ACT_READ;
      default: return i2c_rm_pkg::ACT_DATA;
    endcase
  endfunction

  // How many high samples the scripted target lets pass before acknowledging.
  function automatic int ack_delay_plan();
    if ($urandom_range(99) < abort_pct) return NEVER_ACK;
    return $urandom_range(3);
  endfunction

  // Stop offering, wait for every outstanding result and let the output stage settle, so
  // that the block is quiet before a register write.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      i2c_rm_pkg::CFG_DEV_ADDR:   cfg_dev   = val[6:0];
      i2c_rm_pkg::CFG_POLL_LIMIT: cfg_limit = val[7:0];
      i2c_rm_pkg::CFG_TICKS:      cfg_tpd   = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [6:0] dev, input logic [7:0] limit,
                                input logic [15:0] tpd);
    settle();
    // Unused upper bits carry random values; the registers take their own width only.
    set_register(i2c_rm_pkg::CFG_DEV_ADDR, {9'($urandom), dev});
    set_register(i2c_rm_pkg::CFG_POLL_LIMIT, {8'($urandom), limit});
    set_register(i2c_rm_pkg::CFG_TICKS, tpd);
    settings_used++;
  endtask

  // One register access from begin to STOP. The target acknowledges after a planned number
  // of high samples, read bits are random, and write bytes are supplied after random waits.
  task automatic run_access(input logic [1:0] act, input logic [7:0] regad,
                            input logic [7:0] cnt);
    bus_tick_t t;
    int        ack_after;
    int        acks_left;
    t       = rand_tick(act);
    t.regad = regad;
    t.count = cnt;
    send_tick(t);
    accesses++;
    ack_after = 0;
    acks_left = ack_budget;
    while (p_phase != i2c_rm_pkg::PH_IDLE) begin
      t = rand_tick(i2c_rm_pkg::ACT_TICK);
      if (p_phase != i2c_rm_pkg::PH_ACK_POLL)
        ack_after = (acks_left == 0) ? NEVER_ACK : ack_delay_plan();
      if (p_phase == i2c_rm_pkg::PH_ACK_POLL) begin
        t.sda = (int'(p_polls) >= ack_after) ? 1'b0 : 1'b1;
        if (!t.sda && acks_left > 0) acks_left--;
      end
      if (p_phase == i2c_rm_pkg::PH_WAIT_DATA && $urandom_range(99) < 60)
        t.action = i2c_rm_pkg::ACT_DATA;
      // Misplaced actions: a begin while busy, or a data byte nobody is waiting for.
      if ($urandom_range(99) < noise_pct)
        t.action = (p_phase == i2c_rm_pkg::PH_WAIT_DATA) ?
                   ($urandom_range(1) ? i2c_rm_pkg::ACT_WRITE : i2c_rm_pkg::ACT_READ) :
                   noise_action();
      send_tick(t);
    end
  endtask

  // Plain ticks and data bytes while idle are ignored; the field extremes go by here.
  task automatic test_ignored_actions();
    bus_tick_t t;
    for (int i = 0; i < 4; i++) begin
      t.action = i[0] ? i2c_rm_pkg::ACT_DATA : i2c_rm_pkg::ACT_TICK;
      t.regad  = i[1] ? 8'hFF : 8'h00;
      t.count  = i[1] ? 8'hFF : 8'h00;
      t.wdata  = i[1] ? 8'hFF : 8'h00;
      t.sda    = i[1];
      send_tick(t);
    end
  endtask

  // With no data bytes a write ends after the register byte and a read after the read
  // address; both still finish with STOP. The delay unit is zero here, which acts as one.
  task automatic test_zero_byte_count();
    abort_pct = 0;
    apply_settings(7'h00, 8'd3, 16'd0);
    run_access(i2c_rm_pkg::ACT_WRITE, 8'hFF, 8'd0);
    run_access(i2c_rm_pkg::ACT_READ, 8'h00, 8'd0);
  endtask

  task automatic test_write_and_read();
    apply_settings(7'h7F, 8'd100, 16'd1);
    run_access(i2c_rm_pkg::ACT_WRITE, 8'h5A, 8'd1);
    run_access(i2c_rm_pkg::ACT_READ, 8'hA5, 8'd2);
  endtask

  // A limit of zero gives up on the first high sample.
  task automatic test_ack_polling();
    apply_settings(7'h2A, 8'd0, 16'd1);
    abort_pct = 100;
    run_access(i2c_rm_pkg::ACT_WRITE, 8'h10, 8'd1);
    abort_pct = 0;
  endtask

  // The largest byte count: the target acknowledges the address, the register and one data
  // byte, then stays silent, so the write ends early with STOP and ack_error.
  task automatic test_longest_transfers();
    apply_settings(7'h7F, 8'd3, 16'd1);
    ack_budget = 3;
    run_access(i2c_rm_pkg::ACT_WRITE, 8'hE7, 8'd255);
    ack_budget = -1;
  endtask

  // A larger unit stretches every timed phase.
  task automatic test_delay_units();
    apply_settings(7'h4C, 8'd100, 16'd2);
    run_access(i2c_rm_pkg::ACT_WRITE, 8'h3C, 8'd0);
  endtask

  task automatic test_misplaced_actions();
    apply_settings(7'h11, 8'd100, 16'd1);
    noise_pct = 40;
    run_access(i2c_rm_pkg::ACT_WRITE, 8'h77, 8'd1);
    noise_pct = 0;
  endtask

  // The receiver holds off long enough for the output register to fill, while the sender
  // keeps offering ticks; the input side has to stall and no tick may be lost.
  task automatic test_output_stall();
    int tx_keep;
    int rx_keep;
    tx_keep = tx_idle_pct;
    rx_keep = rx_idle_pct;
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      run_access(i2c_rm_pkg::ACT_WRITE, 8'h3C, 8'd0);
    join
    tx_idle_pct = tx_keep;
    rx_idle_pct = rx_keep;
  endtask

  // The largest delay unit, left last because its access cannot finish in a short run:
  // the bus must sit in the first START phase for every tick sent here.
  task automatic test_slowest_bus();
    apply_settings(7'h7F, 8'd255, 16'hFFFF);
    run_prefix: begin
      bus_tick_t t;
      t       = rand_tick(i2c_rm_pkg::ACT_WRITE);
      t.count = 8'd1;
      send_tick(t);
      accesses++;
      repeat (20) send_tick(rand_tick(noise_action()));
    end
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 33;
    rx_idle_pct = 49;
    test_ignored_actions();
    test_zero_byte_count();
    test_write_and_read();
    test_ack_polling();

    tx_idle_pct = 49;
    rx_idle_pct = 33;
    test_longest_transfers();
    test_delay_units();
    test_misplaced_actions();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_output_stall();
    test_slowest_bus();

    settle();
    $display("Covered %0d ticks in %0d register accesses under %0d settings.",
             ticks_sent, accesses, settings_used);
    $display("Checked %0d results: %0d bytes read, %0d stops, %0d after a missing ack.",
             results_checked, bytes_read, stops_seen, aborts_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/i2c_rm_pkg.sv
hdl/i2c_register_master_core.sv
dv/testbench.sv
